// ----- hw/rtl/pwct_pkg.sv -----
`timescale 1ns / 1ps

package pwct_pkg;

	localparam int BIN_COUNT  = 16;
	localparam int WIDTH_BITS = 16;

	localparam int BIN_IDX_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam int PW_W      = 16;
	localparam int SUM_W     = 2 * PW_W;
	localparam int HITS_W    = 16;
	localparam int LIM_W     = PW_W + 1;
	localparam int PROD_W    = LIM_W + HITS_W;
	localparam int OUT_IDX_W = 4;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;
	localparam int DIV_CNT_W = $clog2(PW_W);

	localparam int PW_KEEP = (WIDTH_BITS < PW_W) ? WIDTH_BITS : PW_W;
	localparam logic [PW_W-1:0] PW_MASK = PW_W'((64'd1 << PW_KEEP) - 64'd1);

	localparam logic [BIN_IDX_W-1:0] BIN_LAST = BIN_IDX_W'(BIN_COUNT - 1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PW_W - 1);
	localparam logic [HITS_W-1:0]    HITS_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CNT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_CNT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEARNING = 8'd3;

	localparam logic [15:0] TOLERANCE_RST  = 16'd200;
	localparam logic [15:0] FIRST_CNT_RST  = 16'd40;
	localparam logic [15:0] SECOND_CNT_RST = 16'd100;
	localparam logic        LEARNING_RST   = 1'b0;

	typedef struct packed {
		logic load;
		logic read;
		logic check;
		logic idx_inc;
		logic div_init;
		logic div_step;
		logic join_commit;
		logic miss_commit;
	} pwct_cmd_t;

	typedef struct packed {
		logic bin_match;
		logic bin_last;
	} pwct_sts_t;

endpackage

// ----- hw/rtl/pwct_ctrl.sv -----
`timescale 1ns / 1ps

module pwct_ctrl
	import pwct_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	input  pwct_sts_t sts,
	output pwct_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_DIV,
		ST_JOIN,
		ST_MISS
	} state_t;

	state_t                 state_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic                   done_q;

	always_comb begin
		cmd             = '0;
		cmd.load        = (state_q == ST_IDLE) && start;
		cmd.read        = (state_q == ST_SCAN);
		cmd.check       = (state_q == ST_CHECK);
		cmd.div_init    = (state_q == ST_CHECK) && sts.bin_match;
		cmd.idx_inc     = (state_q == ST_CHECK) && !sts.bin_match && !sts.bin_last;
		cmd.div_step    = (state_q == ST_DIV);
		cmd.join_commit = (state_q == ST_JOIN);
		cmd.miss_commit = (state_q == ST_MISS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					priority if (sts.bin_match) begin
						state_q <= ST_DIV;
					end else if (sts.bin_last) begin
						state_q <= ST_MISS;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == DIV_LAST) begin
						div_cnt_q <= '0;
						state_q   <= ST_JOIN;
					end else begin
						div_cnt_q <= div_cnt_q + 1'b1;
					end
				end
				ST_JOIN, ST_MISS: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe outside idle");

	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> (state_q == ST_SCAN))
		else $error("accepted item did not start a scan");

	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV) |-> (div_cnt_q == '0))
		else $error("divide step count left over");

endmodule

// ----- hw/rtl/pwct_dp.sv -----
`timescale 1ns / 1ps

module pwct_dp
	import pwct_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  pwct_cmd_t             cmd,
	output pwct_sts_t             sts,
	input  logic [PW_W-1:0]       pulse_width,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data,
	output logic [OUT_IDX_W-1:0]  bin_index,
	output logic                  joined,
	output logic                  opened,
	output logic                  table_full,
	output logic                  report,
	output logic                  push_learned,
	output logic [PW_W-1:0]       bin_average
);

	logic [15:0]            tol_q;
	logic [15:0]            first_q;
	logic [15:0]            second_q;
	logic                   learn_q;

	logic [SUM_W-1:0]       bin_sum_q  [BIN_COUNT];
	logic [HITS_W-1:0]      bin_hits_q [BIN_COUNT];

	logic [PW_W-1:0]        w_q;
	logic                   lo_pos_q;
	logic [LIM_W-1:0]       lo_mag_q;
	logic [LIM_W-1:0]       hi_q;
	logic [BIN_IDX_W-1:0]   idx_q;
	logic                   empty_found_q;
	logic [BIN_IDX_W-1:0]   empty_idx_q;

	logic [SUM_W-1:0]       sum_s1;
	logic [HITS_W-1:0]      hits_s1;
	logic [PROD_W-1:0]      prod_lo_s1;
	logic [PROD_W-1:0]      prod_hi_s1;

	logic [PW_W-1:0]        div_rem_q;
	logic [PW_W-1:0]        div_dvd_q;

	logic [OUT_IDX_W-1:0]   res_idx_q;
	logic                   res_join_q;
	logic                   res_open_q;
	logic                   res_full_q;
	logic                   res_rep_q;
	logic                   res_push_q;
	logic [PW_W-1:0]        res_avg_q;

	logic [PW_W-1:0]        w_in;
	logic [LIM_W:0]         lo_v;
	logic                   lower_ok;
	logic                   upper_ok;
	logic [PW_W:0]          rem_sh;
	logic                   rem_ge;
	logic [SUM_W:0]         sum_add;
	logic [SUM_W-1:0]       sum_new;
	logic [HITS_W-1:0]      hits_new;
	logic                   can_add;
	logic                   hit_report;

	assign w_in = pulse_width & PW_MASK;
	assign lo_v = {2'b00, w_in} + (LIM_W+1)'(1) - {2'b00, tol_q};

	assign lower_ok = !lo_pos_q || ({1'b0, sum_s1} >= prod_lo_s1);
	assign upper_ok = ({1'b0, sum_s1} < prod_hi_s1);

	assign sts.bin_match = (hits_s1 != '0) && lower_ok && upper_ok;
	assign sts.bin_last  = (idx_q == BIN_LAST);

	assign rem_sh = {div_rem_q, div_dvd_q[PW_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, hits_s1});

	assign sum_add    = {1'b0, sum_s1} + (SUM_W+1)'(w_q);
	assign sum_new    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
	assign hits_new   = hits_s1 + 1'b1;
	assign can_add    = (hits_s1 != HITS_MAX);
	assign hit_report = can_add && ((hits_new == first_q) || (hits_new == second_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= TOLERANCE_RST;
			first_q  <= FIRST_CNT_RST;
			second_q <= SECOND_CNT_RST;
			learn_q  <= LEARNING_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOLERANCE:  tol_q    <= cfg_data;
				REG_FIRST_CNT:  first_q  <= cfg_data;
				REG_SECOND_CNT: second_q <= cfg_data;
				REG_LEARNING:   learn_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BIN_COUNT; k++) begin
				bin_hits_q[k] <= '0;
			end
		end else if (cmd.join_commit && can_add) begin
			bin_hits_q[idx_q] <= hits_new;
		end else if (cmd.miss_commit && empty_found_q) begin
			bin_hits_q[empty_idx_q] <= HITS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.join_commit && can_add) begin
			bin_sum_q[idx_q] <= sum_new;
		end else if (cmd.miss_commit && empty_found_q) begin
			bin_sum_q[empty_idx_q] <= SUM_W'(w_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q      <= w_in;
			lo_pos_q <= !lo_v[LIM_W] && (lo_v != '0);
			lo_mag_q <= lo_v[LIM_W-1:0];
			hi_q     <= LIM_W'(w_in) + LIM_W'(tol_q);
		end
		if (cmd.read) begin
			sum_s1     <= bin_sum_q[idx_q];
			hits_s1    <= bin_hits_q[idx_q];
			prod_lo_s1 <= PROD_W'(lo_mag_q) * PROD_W'(bin_hits_q[idx_q]);
			prod_hi_s1 <= PROD_W'(hi_q) * PROD_W'(bin_hits_q[idx_q]);
		end
		if (cmd.div_init) begin
			div_rem_q <= sum_s1[SUM_W-1:PW_W];
			div_dvd_q <= sum_s1[PW_W-1:0];
		end else if (cmd.div_step) begin
			div_rem_q <= rem_ge ? PW_W'(rem_sh - {1'b0, hits_s1}) : rem_sh[PW_W-1:0];
			div_dvd_q <= {div_dvd_q[PW_W-2:0], rem_ge};
		end
		if (cmd.join_commit || cmd.miss_commit) begin
			res_avg_q <= cmd.join_commit ? div_dvd_q : '0;
			res_idx_q <= cmd.join_commit ? OUT_IDX_W'(idx_q)
				: (empty_found_q ? OUT_IDX_W'(empty_idx_q) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			empty_found_q <= 1'b0;
			empty_idx_q   <= '0;
			res_join_q    <= 1'b0;
			res_open_q    <= 1'b0;
			res_full_q    <= 1'b0;
			res_rep_q     <= 1'b0;
			res_push_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q         <= '0;
				empty_found_q <= 1'b0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.check && (hits_s1 == '0) && !empty_found_q) begin
				empty_found_q <= 1'b1;
				empty_idx_q   <= idx_q;
			end
			if (cmd.join_commit || cmd.miss_commit) begin
				res_join_q <= cmd.join_commit;
				res_open_q <= cmd.miss_commit && empty_found_q;
				res_full_q <= cmd.miss_commit && !empty_found_q;
				res_rep_q  <= cmd.join_commit && hit_report;
				res_push_q <= cmd.join_commit && hit_report && learn_q;
			end
		end
	end

	assign bin_index    = res_idx_q;
	assign joined       = res_join_q;
	assign opened       = res_open_q;
	assign table_full   = res_full_q;
	assign report       = res_rep_q;
	assign push_learned = res_push_q;
	assign bin_average  = res_avg_q;

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (div_rem_q < hits_s1))
		else $error("divider remainder not below the bin count");

	a_push_rep: assert property (@(posedge clk) disable iff (!arst_n)
		res_push_q |-> (res_rep_q && res_join_q))
		else $error("push without a report on a join");

	a_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.join_commit || cmd.miss_commit)
			|-> $onehot({res_join_q, res_open_q, res_full_q}))
		else $error("result outcome not exactly one of join, open, full");

endmodule

// ----- hw/rtl/pulse_width_cluster_tracker_core.sv -----
`timescale 1ns / 1ps
// An item taken at a start edge yields one result, strobed by done.
// The scan reads each bin in ST_SCAN and tests it in ST_CHECK, and stops at the first match.
// A join then runs a shift-and-subtract divide for the bin average.
// A miss also strobes its result through done; busy is low in the strobe cycle.
// Asynchronous reset empties all bins and loads the register defaults.
// The receiver cannot stall; done is high for one cycle only, and the result outputs hold until the next result.

module pulse_width_cluster_tracker_core
	import pwct_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [PW_W-1:0]       pulse_width,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data,
	output logic                  done,
	output logic [OUT_IDX_W-1:0]  bin_index,
	output logic                  joined,
	output logic                  opened,
	output logic                  table_full,
	output logic                  report,
	output logic                  push_learned,
	output logic [PW_W-1:0]       bin_average
);

	pwct_cmd_t cmd;
	pwct_sts_t sts;

	assign cfg_ready = 1'b1;

	pwct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	pwct_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.pulse_width  (pulse_width),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.bin_index    (bin_index),
		.joined       (joined),
		.opened       (opened),
		.table_full   (table_full),
		.report       (report),
		.push_learned (push_learned),
		.bin_average  (bin_average)
	);

endmodule
